// ===== rtl/core/spkq_pkg.sv =====
`default_nettype none
package spkq_pkg;
	localparam int HeadDim    = 128;
	localparam int ProjDim    = 256;
	localparam int StoreDepth = HeadDim * ProjDim;
	localparam int SignBytes  = ProjDim / 8;
	localparam int AddrW      = 15;
	localparam int ColW       = 8;
	localparam int IdxW       = 7;
	localparam int AccW       = 39;
	localparam int SqW        = 38;
	localparam int NormW      = 19;
	localparam int ByteW      = 5;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_KEY  = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/core/spkq_mem.sv =====
`default_nettype none
// projection store, one write and one read per cycle, registered read data
module spkq_mem import spkq_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    we,
	input  wire logic [AddrW-1:0]        waddr,
	input  wire logic signed [15:0]      wdata,
	input  wire logic [AddrW-1:0]        raddr,
	output logic signed [15:0]           rdata
);
	logic signed [15:0] mem_q [StoreDepth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/spkq_acc.sv =====
`default_nettype none
// column accumulator memory: registered read, one read port shared by the mac read-modify-write and the sign scan
module spkq_acc import spkq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [ColW-1:0]       waddr,
	input  wire logic signed [AccW-1:0] wdata,
	input  wire logic [ColW-1:0]       raddr,
	output logic signed [AccW-1:0]     rdata
);
	logic signed [AccW-1:0] acc_q [ProjDim];
	always_ff @(posedge clk) begin
		if (we) acc_q[waddr] <= wdata;
		rdata <= acc_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/sign_projection_key_quantizer.sv =====
`default_nettype none
// channel | signals                                               | dir
// in      | valid ready kind matrix_address matrix_value          | in
//         | key_index key_value                                   |
// out     | valid ready byte_index sign_byte key_norm last_of_row | out
// a load beat leaves in_ready high; a key beat drops in_ready for one store read
// per column over 256 columns, then a pipe drain (multiply, accumulator read-add-write)
// the final key beat adds 19 sqrt steps and 32 output beats, each built from
// 8 accumulator reads through the same port, then a state holding the beat
// index zero and the first key beat after reset write the product alone (sums start at 0)
// stalls on out_ready hold the sequencer; in_ready is low while busy
module sign_projection_key_quantizer import spkq_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                kind,
	input  wire logic [14:0]         matrix_address,
	input  wire logic signed [15:0]  matrix_value,
	input  wire logic [6:0]          key_index,
	input  wire logic signed [15:0]  key_value,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [4:0]               byte_index,
	output logic [7:0]               sign_byte,
	output logic [18:0]              key_norm,
	output logic                     last_of_row
);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_MAC = 3'd1, ST_SQRT = 3'd2,
		ST_SCAN = 3'd3, ST_OUT = 3'd4;

	logic [2:0] state_q;
	logic [8:0] cnt_q;          // issue counter, runs past the last column for pipe drain
	logic wv_q, wv2_q;
	logic signed [15:0] key_q;
	logic [IdxW-1:0] idx_q;
	logic clr_q;
	logic fresh_q;
	logic [SqW-1:0] sq_q, rem_q;
	logic [NormW-1:0] root_q;
	logic [4:0] sstep_q;
	logic [4:0] byte_q;
	logic [3:0] bit_q;
	logic [7:0] sbyte_q;
	logic signed [15:0] mrd;
	logic signed [AccW-1:0] ard, awd;
	logic signed [31:0] prod_s1;
	logic [ColW-1:0] col_s1, col_s2;
	logic [ColW-1:0] araddr;
	logic [ColW-1:0] issue_col;

	assign in_ready = (state_q == ST_IDLE);
	wire acc_beat = in_valid && in_ready;
	wire idx_ok   = {1'b0, key_index} < (IdxW+1)'(HeadDim);

	assign issue_col = cnt_q[ColW-1:0];

	spkq_mem u_mem (
		.clk(clk),
		.we(acc_beat && kind == KIND_LOAD && {1'b0, matrix_address} < 16'(StoreDepth)),
		.waddr(matrix_address), .wdata(matrix_value),
		.raddr({idx_q, issue_col}), .rdata(mrd)
	);

	// mac pipe: s0 issue reads, s1 multiply, s2 add and write
	assign araddr = (state_q == ST_SCAN) ? {byte_q, bit_q[2:0]} : col_s1;
	assign awd = clr_q ? AccW'(prod_s1) : ard + AccW'(prod_s1);

	spkq_acc u_acc (
		.clk(clk), .we(wv2_q), .waddr(col_s2), .wdata(awd),
		.raddr(araddr), .rdata(ard)
	);

	// sqrt trial
	wire [SqW+1:0] tv = ({2'b0, SqW'(root_q)} << (sstep_q + 5'd1)) +
		(({{(SqW+1){1'b0}}, 1'b1}) << {sstep_q, 1'b0});
	wire ge = {2'b0, rem_q} >= tv;

	always_ff @(posedge clk) begin
		prod_s1 <= key_q * mrd;
		col_s1  <= issue_col;
		col_s2  <= col_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; cnt_q <= '0; wv_q <= 1'b0; wv2_q <= 1'b0;
			out_valid <= 1'b0; sq_q <= '0; clr_q <= 1'b0; fresh_q <= 1'b1;
		end else begin
			wv2_q <= wv_q;
			unique case (state_q)
				ST_IDLE: begin
					wv_q <= 1'b0;
					if (acc_beat && kind == KIND_KEY && idx_ok) begin
						key_q <= key_value; idx_q <= key_index;
						clr_q <= (key_index == '0) || fresh_q;
						fresh_q <= 1'b0;
						sq_q <= (key_index == '0 ? '0 : sq_q) +
							SqW'($unsigned(32'(key_value * key_value)));
						cnt_q <= '0; state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					// read issued at cnt, store data valid next cycle
					wv_q <= !cnt_q[8];
					cnt_q <= cnt_q + 9'd1;
					if (cnt_q == 9'd257) begin
						if (idx_q == IdxW'(HeadDim - 1)) begin
							rem_q <= sq_q; root_q <= '0; sstep_q <= 5'd18;
							state_q <= ST_SQRT;
						end else state_q <= ST_IDLE;
					end
				end
				ST_SQRT: begin
					if (ge) begin
						rem_q <= rem_q - SqW'(tv);
						root_q <= root_q | (NormW'(1) << sstep_q);
					end
					sstep_q <= sstep_q - 5'd1;
					if (sstep_q == '0) begin
						byte_q <= '0; bit_q <= '0; state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// bit_q addresses the read; data arrives on the next cycle
					bit_q <= bit_q + 4'd1;
					if (bit_q != '0)
						sbyte_q <= {!ard[AccW-1] && ard != '0, sbyte_q[7:1]};
					if (bit_q == 4'd8) begin
						out_valid <= 1'b1;
						byte_index <= byte_q;
						sign_byte <= {!ard[AccW-1] && ard != '0, sbyte_q[7:1]};
						last_of_row <= byte_q == 5'(SignBytes - 1);
						key_norm <= byte_q == 5'(SignBytes - 1) ? root_q : '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						bit_q <= '0;
						byte_q <= byte_q + 5'd1;
						state_q <= last_of_row ? ST_IDLE : ST_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
